// ----- rtl/core/ifc_pkg.sv -----
// ----------------------------------------------------------------------------
// ifc_pkg
// Shared types and constants of the integer field checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ifc_pkg;

    localparam int ACC_WIDTH = 34;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_BOUND = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_BOUND = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NULLABLE  = 2'd2;

    localparam logic [31:0] MIN_BOUND_RESET = 32'h8000_0000;
    localparam logic [30:0] MAX_BOUND_RESET = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_INTERRUPTED  = 3'd1,
        STATUS_TOO_SMALL    = 3'd2,
        STATUS_TOO_LARGE    = 3'd3,
        STATUS_BAD_FORMAT   = 3'd4,
        STATUS_INVALID_NULL = 3'd5
    } status_t;

    typedef struct packed {
        logic signed [31:0] min_bound;
        logic [30:0]        max_bound;
        logic               nullable;
    } cfg_t;

    // Field summary handed from the scanner to the clamp stage.
    typedef struct packed {
        logic                 empty;
        logic                 format_error;
        logic                 cut;
        logic                 negative;
        logic [ACC_WIDTH-1:0] magnitude;
    } field_snap_t;

endpackage

`default_nettype wire

// ----- rtl/core/ifc_if.sv -----
// ----------------------------------------------------------------------------
// ifc_char_if / ifc_result_if
// Valid/ready channels for character words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       char_valid;
    logic       field_end;

    modport source (output valid, output char_code, output char_valid,
                    output field_end, input ready);
    modport sink   (input valid, input char_code, input char_valid,
                    input field_end, output ready);
endinterface

interface ifc_result_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    ifc_pkg::status_t              status;
    logic                          is_null;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output status, output is_null,
                    output value, input ready);
    modport sink   (input valid, input status, input is_null,
                    input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/integer_field_checker.sv -----
// ----------------------------------------------------------------------------
// integer_field_checker
// Checks and converts decimal text fields, one character word per cycle when not stalled.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word contents
//  chars     in   valid/ready    char_code, char_valid, field_end
//  results   out  valid/ready    status, is_null, value
//  cfg       in   cfg_we         cfg_index, cfg_data (write only)
//
//  One character word accepted per cycle while no field-end word waits on a
//  stalled result; a result word follows the word with field_end through the
//  input register, field summary register and result register.
//  Reset clears the parse state and loads the bound registers with defaults.
//  A stalled result blocks only field-end words, and with them every word behind.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_field_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [ifc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [ifc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    ifc_char_if.sink                                    chars,
    ifc_result_if.source                                results
);

    ifc_pkg::cfg_t        cfg_reg;
    ifc_pkg::field_snap_t snap;
    logic                 snap_valid;
    logic                 snap_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_bound <= signed'(ifc_pkg::MIN_BOUND_RESET);
            cfg_reg.max_bound <= ifc_pkg::MAX_BOUND_RESET;
            cfg_reg.nullable  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ifc_pkg::CFG_MIN_BOUND: cfg_reg.min_bound <= signed'(cfg_data);
                ifc_pkg::CFG_MAX_BOUND: cfg_reg.max_bound <= cfg_data[30:0];
                ifc_pkg::CFG_NULLABLE:  cfg_reg.nullable  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    ifc_char_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready)
    );

    ifc_range_clamp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_clamp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .results    (results)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ifc_char_scan.sv -----
// ----------------------------------------------------------------------------
// ifc_char_scan
// Input register, per-field parse state and the field summary register.
// ----------------------------------------------------------------------------
`default_nettype none

module ifc_char_scan (
    input  wire logic                clk,
    input  wire logic                rst_n,
    ifc_char_if.sink                 chars,
    output ifc_pkg::field_snap_t     snap,
    output logic                     snap_valid,
    input  wire logic                snap_ready
);

    localparam int AW = ifc_pkg::ACC_WIDTH;

    logic       in_v_reg;
    logic [7:0] in_char_reg;
    logic       in_cv_reg;
    logic       in_end_reg;

    logic          pos_reg, pos_next;
    logic          neg_reg, neg_next;
    logic          done_reg, done_next;
    logic          cut_reg, cut_next;
    logic          fmt_reg, fmt_next;
    logic [AW-1:0] acc_reg, acc_next;

    logic                 snap_v_reg;
    ifc_pkg::field_snap_t snap_reg;

    logic          go;
    logic          is_digit;
    logic [3:0]    digit;
    logic [AW+3:0] acc_x10;
    logic [AW-1:0] acc_digit;

    assign go = in_v_reg && (!in_end_reg || !snap_v_reg || snap_ready);
    assign chars.ready = !in_v_reg || go;

    assign is_digit = (in_char_reg >= ifc_pkg::CHAR_ZERO)
                   && (in_char_reg <= ifc_pkg::CHAR_NINE);
    assign digit = 4'(in_char_reg - ifc_pkg::CHAR_ZERO);

    // acc*10 + d, saturating; fits in AW+4 bits
    assign acc_x10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + (AW + 4)'(digit);
    assign acc_digit = (acc_x10 > (AW + 4)'(ifc_pkg::ACC_MAX))
                     ? ifc_pkg::ACC_MAX : acc_x10[AW-1:0];

    always_comb
    begin
        pos_next  = pos_reg;
        neg_next  = neg_reg;
        done_next = done_reg;
        cut_next  = cut_reg;
        fmt_next  = fmt_reg;
        acc_next  = acc_reg;
        if (in_cv_reg)
        begin
            if (!pos_reg)
            begin
                pos_next = 1'b1;
                if (in_char_reg == ifc_pkg::CHAR_MINUS)
                begin
                    neg_next = 1'b1;
                end
                else if (is_digit)
                begin
                    acc_next = AW'(digit);
                end
                else
                begin
                    fmt_next = 1'b1;
                end
            end
            else if (!fmt_reg && !cut_reg)
            begin
                if (!is_digit && in_char_reg != ifc_pkg::CHAR_DOT
                    && in_char_reg != ifc_pkg::CHAR_MINUS)
                begin
                    cut_next = 1'b1;
                end
                else if (!done_reg)
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_digit;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            pos_reg    <= 1'b0;
            neg_reg    <= 1'b0;
            done_reg   <= 1'b0;
            cut_reg    <= 1'b0;
            fmt_reg    <= 1'b0;
            acc_reg    <= '0;
            snap_v_reg <= 1'b0;
        end
        else
        begin
            if (chars.ready)
            begin
                in_v_reg <= chars.valid;
            end
            if (go)
            begin
                if (in_end_reg)
                begin
                    pos_reg  <= 1'b0;
                    neg_reg  <= 1'b0;
                    done_reg <= 1'b0;
                    cut_reg  <= 1'b0;
                    fmt_reg  <= 1'b0;
                    acc_reg  <= '0;
                end
                else
                begin
                    pos_reg  <= pos_next;
                    neg_reg  <= neg_next;
                    done_reg <= done_next;
                    cut_reg  <= cut_next;
                    fmt_reg  <= fmt_next;
                    acc_reg  <= acc_next;
                end
            end
            if (go && in_end_reg)
            begin
                snap_v_reg <= 1'b1;
            end
            else if (snap_ready)
            begin
                snap_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            in_char_reg <= chars.char_code;
            in_cv_reg   <= chars.char_valid;
            in_end_reg  <= chars.field_end;
        end
        if (go && in_end_reg)
        begin
            snap_reg.empty        <= !pos_next;
            snap_reg.format_error <= fmt_next;
            snap_reg.cut          <= cut_next;
            snap_reg.negative     <= neg_next;
            snap_reg.magnitude    <= acc_next;
        end
    end

    assign snap       = snap_reg;
    assign snap_valid = snap_v_reg;

    // field state starts clean after each field end
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (go && in_end_reg) |=> (!pos_reg && !neg_reg && !cut_reg && !fmt_reg
                                && !done_reg && acc_reg == '0))
        else $error("field state not cleared after field end");

    a_flags_need_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (fmt_reg || neg_reg || done_reg || cut_reg) |-> pos_reg)
        else $error("parse flag set before first character");

    a_no_snap_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_v_reg && !snap_ready) |=> (snap_v_reg && $stable(snap_reg)))
        else $error("pending field summary lost");

endmodule

`default_nettype wire

// ----- rtl/core/ifc_range_clamp.sv -----
// ----------------------------------------------------------------------------
// ifc_range_clamp
// Flags null and format errors, signs and clamps the field summary against the bounds; result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ifc_range_clamp #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ifc_pkg::cfg_t        cfg,
    input  wire ifc_pkg::field_snap_t snap,
    input  wire logic                 snap_valid,
    output logic                      snap_ready,
    ifc_result_if.source              results
);

    localparam int AW = ifc_pkg::ACC_WIDTH;
    localparam int XW = AW + 2;

    logic                          out_v_reg;
    ifc_pkg::status_t              status_reg, status_next;
    logic                          is_null_reg, is_null_next;
    logic signed [VALUE_WIDTH-1:0] value_reg, value_next;

    logic signed [XW-1:0] mag_s;
    logic signed [XW-1:0] v_s;
    logic signed [XW-1:0] min_s;
    logic signed [XW-1:0] max_s;
    logic signed [XW-1:0] max_m1;

    assign snap_ready = !out_v_reg || results.ready;

    assign mag_s  = signed'({2'b00, snap.magnitude});
    assign v_s    = snap.negative ? -mag_s : mag_s;
    assign min_s  = XW'(cfg.min_bound);
    assign max_s  = signed'(XW'(cfg.max_bound));
    assign max_m1 = max_s - XW'(1);

    always_comb
    begin
        status_next  = ifc_pkg::STATUS_OK;
        is_null_next = 1'b0;
        value_next   = '0;
        if (snap.empty)
        begin
            if (cfg.nullable)
            begin
                is_null_next = 1'b1;
            end
            else
            begin
                status_next = ifc_pkg::STATUS_INVALID_NULL;
            end
        end
        else if (snap.format_error)
        begin
            status_next = ifc_pkg::STATUS_BAD_FORMAT;
        end
        else if (v_s < min_s)
        begin
            status_next = ifc_pkg::STATUS_TOO_SMALL;
            value_next  = min_s[VALUE_WIDTH-1:0];
        end
        else if (v_s > max_s || (v_s == max_s && cfg.nullable))
        begin
            status_next = ifc_pkg::STATUS_TOO_LARGE;
            value_next  = max_m1[VALUE_WIDTH-1:0];
        end
        else
        begin
            status_next = snap.cut ? ifc_pkg::STATUS_INTERRUPTED : ifc_pkg::STATUS_OK;
            value_next  = v_s[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            out_v_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready && snap_valid)
        begin
            status_reg  <= status_next;
            is_null_reg <= is_null_next;
            value_reg   <= value_next;
        end
    end

    assign results.valid   = out_v_reg;
    assign results.status  = status_reg;
    assign results.is_null = is_null_reg;
    assign results.value   = value_reg;

    a_null_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && is_null_reg) |-> (status_reg == ifc_pkg::STATUS_OK
                                        && value_reg == '0))
        else $error("null word with status or value");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && (status_reg == ifc_pkg::STATUS_BAD_FORMAT
                       || status_reg == ifc_pkg::STATUS_INVALID_NULL))
        |-> (value_reg == '0 && !is_null_reg))
        else $error("error word carries a value");

    a_summary_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid && snap_ready) |=> out_v_reg)
        else $error("field summary dropped");

endmodule

`default_nettype wire
